// ===== rtl/lbcf_pkg.sv =====
`timescale 1ns / 1ps

package lbcf_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_LIMIT = 2'd1;

    localparam logic [15:0] GAP_TIMEOUT_RST = 16'd256;
    localparam logic [7:0]  FLASH_LIMIT_RST = 8'd7;
    localparam logic [15:0] GAP_MAX         = 16'hFFFF;

    localparam logic [7:0] EE_FRAME_LEN = 8'h08;
    localparam logic [7:0] EE_TAG_HI    = 8'h45;
    localparam logic [7:0] EE_TAG_LO    = 8'h50;
    localparam logic [7:0] FLASH_CMD    = 8'hEF;

    localparam int HDR_BYTES     = 5;
    localparam int PAYLOAD_START = 5;

    typedef enum logic [2:0] {
        KIND_KICK       = 3'd0,
        KIND_EE_WRITE   = 3'd1,
        KIND_PAGE_LOAD  = 3'd2,
        KIND_PAGE_ERASE = 3'd3,
        KIND_PAGE_WRITE = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_KICK,
        ST_EE,
        ST_RD_LO,
        ST_RD_HI,
        ST_WORD,
        ST_ERASE,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic  s_ready;
        logic  out_load;
        kind_t out_kind;
        logic  out_last;
        logic  rd_en;
        logic  lo_cap;
        logic  flash_start;
        logic  word_adv;
    } ctl_cmd_t;

    typedef struct packed {
        logic frame_done;
        logic is_ee;
        logic is_flash;
        logic out_free;
        logic word_end;
    } dp_status_t;

endpackage

// ===== rtl/lbcf_ctrl.sv =====
`timescale 1ns / 1ps

module lbcf_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  lbcf_pkg::dp_status_t  st,
    output lbcf_pkg::ctl_cmd_t    cmd
);

    lbcf_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lbcf_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lbcf_pkg::ST_IDLE: begin
                if (s_valid) state_next = lbcf_pkg::ST_CHECK;
            end
            lbcf_pkg::ST_CHECK: begin
                state_next = st.frame_done ? lbcf_pkg::ST_KICK : lbcf_pkg::ST_IDLE;
            end
            lbcf_pkg::ST_KICK: begin
                if (st.out_free) begin
                    if (st.is_ee)         state_next = lbcf_pkg::ST_EE;
                    else if (st.is_flash) state_next = lbcf_pkg::ST_RD_LO;
                    else                  state_next = lbcf_pkg::ST_IDLE;
                end
            end
            lbcf_pkg::ST_EE: begin
                if (st.out_free) state_next = lbcf_pkg::ST_IDLE;
            end
            lbcf_pkg::ST_RD_LO: state_next = lbcf_pkg::ST_RD_HI;
            lbcf_pkg::ST_RD_HI: state_next = lbcf_pkg::ST_WORD;
            lbcf_pkg::ST_WORD: begin
                if (st.out_free) begin
                    state_next = st.word_end ? lbcf_pkg::ST_ERASE : lbcf_pkg::ST_RD_LO;
                end
            end
            lbcf_pkg::ST_ERASE: begin
                if (st.out_free) state_next = lbcf_pkg::ST_WRITE;
            end
            lbcf_pkg::ST_WRITE: begin
                if (st.out_free) state_next = lbcf_pkg::ST_IDLE;
            end
            default: state_next = lbcf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd             = '0;
        cmd.out_kind    = lbcf_pkg::KIND_KICK;
        unique case (state_reg)
            lbcf_pkg::ST_IDLE: begin
                cmd.s_ready = aresetn;
            end
            lbcf_pkg::ST_CHECK: begin
            end
            lbcf_pkg::ST_KICK: begin
                cmd.out_load    = st.out_free;
                cmd.out_kind    = lbcf_pkg::KIND_KICK;
                cmd.out_last    = !(st.is_ee || st.is_flash);
                cmd.flash_start = st.out_free && st.is_flash;
            end
            lbcf_pkg::ST_EE: begin
                cmd.out_load = st.out_free;
                cmd.out_kind = lbcf_pkg::KIND_EE_WRITE;
                cmd.out_last = 1'b1;
            end
            lbcf_pkg::ST_RD_LO: begin
                cmd.rd_en = 1'b1;
            end
            lbcf_pkg::ST_RD_HI: begin
                cmd.rd_en  = 1'b1;
                cmd.lo_cap = 1'b1;
            end
            lbcf_pkg::ST_WORD: begin
                cmd.out_load = st.out_free;
                cmd.out_kind = lbcf_pkg::KIND_PAGE_LOAD;
                cmd.word_adv = st.out_free;
            end
            lbcf_pkg::ST_ERASE: begin
                cmd.out_load = st.out_free;
                cmd.out_kind = lbcf_pkg::KIND_PAGE_ERASE;
            end
            lbcf_pkg::ST_WRITE: begin
                cmd.out_load = st.out_free;
                cmd.out_kind = lbcf_pkg::KIND_PAGE_WRITE;
                cmd.out_last = 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/lbcf_dp.sv =====
`timescale 1ns / 1ps

module lbcf_dp #(
    parameter int BUF_BYTES  = 48,
    parameter int PAGE_BYTES = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [lbcf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lbcf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_valid,
    input  logic                              s_func,
    input  logic [7:0]                        s_rx_byte,
    input  logic                              m_ready,
    output logic                              m_valid,
    output logic [2:0]                        m_kind,
    output logic [15:0]                       m_address,
    output logic [15:0]                       m_data,
    output logic                              m_last,
    input  lbcf_pkg::ctl_cmd_t                cmd,
    output lbcf_pkg::dp_status_t              st
);

    localparam int FL_LEN  = lbcf_pkg::PAYLOAD_START + PAGE_BYTES;
    localparam int FL_END  = lbcf_pkg::PAYLOAD_START + 2 * (PAGE_BYTES / 2);
    localparam int PTR_MAX = (BUF_BYTES > FL_LEN) ? BUF_BYTES : FL_LEN;
    localparam int PTR_W   = $clog2(PTR_MAX + 1);
    localparam int IDX_W   = $clog2(BUF_BYTES);

    logic [15:0]      gap_timeout_reg;
    logic [7:0]       flash_limit_reg;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [15:0]      gap_reg, gap_next;
    logic             done_reg, done_next;
    logic             ee_reg, ee_next;
    logic             fl_reg, fl_next;
    logic [7:0]       hdr_reg [lbcf_pkg::HDR_BYTES];
    logic [7:0]       mem [BUF_BYTES];
    logic [7:0]       rd_data_reg;
    logic [7:0]       lo_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [15:0]      addr_reg;
    logic             m_valid_reg, m_valid_next;
    logic [2:0]       m_kind_reg;
    logic [15:0]      m_address_reg;
    logic [15:0]      m_data_reg;
    logic             m_last_reg;

    logic             s_fire, byte_fire, tick_fire, wr_en;
    logic [PTR_W-1:0] wp_inc;
    logic [7:0]       b0;
    logic             complete, ee_hit, fl_hit;
    logic [15:0]      gap_inc;
    logic [15:0]      base;
    logic             out_free;
    logic [15:0]      out_addr, out_data;

    assign s_fire    = s_valid && cmd.s_ready;
    assign byte_fire = s_fire && !s_func;
    assign tick_fire = s_fire && s_func;
    assign wr_en     = byte_fire && (wp_reg < PTR_W'(BUF_BYTES));
    assign wp_inc    = (wp_reg < PTR_W'(BUF_BYTES)) ? wp_reg + PTR_W'(1) : wp_reg;
    assign b0        = (wp_reg == '0) ? s_rx_byte : hdr_reg[0];
    assign complete  = (wp_inc != '0) && (8'(wp_inc) == b0);
    assign ee_hit    = complete && (wp_inc == PTR_W'(lbcf_pkg::EE_FRAME_LEN))
                       && (hdr_reg[1] == lbcf_pkg::EE_TAG_HI)
                       && (hdr_reg[2] == lbcf_pkg::EE_TAG_LO);
    assign fl_hit    = complete && (wp_inc == PTR_W'(FL_LEN))
                       && (hdr_reg[1] == lbcf_pkg::FLASH_CMD)
                       && (hdr_reg[4] < flash_limit_reg);
    assign gap_inc   = (gap_reg == lbcf_pkg::GAP_MAX) ? gap_reg : gap_reg + 16'd1;
    assign base      = {hdr_reg[4], hdr_reg[3]};
    assign out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_timeout_reg <= lbcf_pkg::GAP_TIMEOUT_RST;
            flash_limit_reg <= lbcf_pkg::FLASH_LIMIT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                lbcf_pkg::CFG_GAP_TIMEOUT: gap_timeout_reg <= cfg_wdata;
                lbcf_pkg::CFG_FLASH_LIMIT: flash_limit_reg <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        wp_next   = wp_reg;
        gap_next  = gap_reg;
        done_next = done_reg;
        ee_next   = ee_reg;
        fl_next   = fl_reg;
        if (byte_fire) begin
            wp_next   = complete ? '0 : wp_inc;
            gap_next  = '0;
            done_next = complete;
            ee_next   = ee_hit;
            fl_next   = fl_hit;
        end else if (tick_fire) begin
            gap_next  = gap_inc;
            if (wp_reg != '0 && gap_inc >= gap_timeout_reg) wp_next = '0;
            done_next = 1'b0;
            ee_next   = 1'b0;
            fl_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= '0;
            gap_reg  <= '0;
            done_reg <= 1'b0;
            ee_reg   <= 1'b0;
            fl_reg   <= 1'b0;
        end else begin
            wp_reg   <= wp_next;
            gap_reg  <= gap_next;
            done_reg <= done_next;
            ee_reg   <= ee_next;
            fl_reg   <= fl_next;
        end
    end

    // Keep the header bytes in flops for the decode
    always_ff @(posedge aclk) begin
        if (wr_en && wp_reg < PTR_W'(lbcf_pkg::HDR_BYTES)) begin
            hdr_reg[wp_reg[2:0]] <= s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wp_reg[IDX_W-1:0]] <= s_rx_byte;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_ptr_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.lo_cap) lo_reg <= rd_data_reg;
        if (cmd.flash_start) begin
            rd_ptr_reg <= PTR_W'(lbcf_pkg::PAYLOAD_START);
            addr_reg   <= base;
        end else begin
            if (cmd.rd_en)    rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            if (cmd.word_adv) addr_reg   <= addr_reg + 16'd2;
        end
    end

    always_comb begin
        out_addr = '0;
        out_data = '0;
        case (cmd.out_kind)
            lbcf_pkg::KIND_EE_WRITE: begin
                out_addr = {8'd0, hdr_reg[3]};
                out_data = {8'd0, hdr_reg[4]};
            end
            lbcf_pkg::KIND_PAGE_LOAD: begin
                out_addr = addr_reg;
                out_data = {rd_data_reg, lo_reg};
            end
            lbcf_pkg::KIND_PAGE_ERASE, lbcf_pkg::KIND_PAGE_WRITE: begin
                out_addr = base;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load)  m_valid_next = 1'b1;
        else if (m_ready)  m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_kind_reg    <= cmd.out_kind;
            m_address_reg <= out_addr;
            m_data_reg    <= out_data;
            m_last_reg    <= cmd.out_last;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_kind    = m_kind_reg;
    assign m_address = m_address_reg;
    assign m_data    = m_data_reg;
    assign m_last    = m_last_reg;

    assign st.frame_done = done_reg;
    assign st.is_ee      = ee_reg;
    assign st.is_flash   = fl_reg;
    assign st.out_free   = out_free;
    assign st.word_end   = (rd_ptr_reg == PTR_W'(FL_END));

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> out_free)
        else $error("result loaded over a pending item");
    a_done_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (byte_fire && complete) |=> (wp_reg == '0))
        else $error("write pointer not cleared after a complete frame");
    a_tick_no_done: assert property (@(posedge aclk) disable iff (!aresetn)
        tick_fire |=> !done_reg && !ee_reg && !fl_reg)
        else $error("tick flagged a frame");
    a_wp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        wp_reg <= PTR_W'(BUF_BYTES))
        else $error("write pointer beyond buffer");
    a_cmd_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !(ee_reg && fl_reg))
        else $error("frame decoded as two commands");
`endif

endmodule

// ===== rtl/length_prefixed_boot_command_framer_core.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_func, s_rx_byte
// m_        out        m_valid / m_ready  m_kind, m_address, m_data, m_last
// cfg_      in         cfg_we             cfg_index, cfg_wdata
//
// A tick or a byte that completes no frame goes from ST_CHECK back to ST_IDLE.
// A kick-only frame steps through ST_CHECK and ST_KICK, an EEPROM frame adds ST_EE;
// a flash frame adds ST_RD_LO, ST_RD_HI, ST_WORD per page word, then ST_ERASE and
// ST_WRITE; the frame buffer's single read port needs two reads per page word.
// Reset is synchronous and active low; the frame buffer is not cleared.
// A stalled m_ready holds the sequencer; s_ready is high only between items.

module length_prefixed_boot_command_framer_core #(
    parameter int BUF_BYTES  = 48,
    parameter int PAGE_BYTES = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [lbcf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lbcf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_func,
    input  logic [7:0]                        s_rx_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [2:0]                        m_kind,
    output logic [15:0]                       m_address,
    output logic [15:0]                       m_data,
    output logic                              m_last
);

    lbcf_pkg::ctl_cmd_t   cmd;
    lbcf_pkg::dp_status_t st;

    lbcf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .st      (st),
        .cmd     (cmd)
    );

    lbcf_dp #(
        .BUF_BYTES  (BUF_BYTES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_func    (s_func),
        .s_rx_byte (s_rx_byte),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_kind    (m_kind),
        .m_address (m_address),
        .m_data    (m_data),
        .m_last    (m_last),
        .cmd       (cmd),
        .st        (st)
    );

    assign s_ready = cmd.s_ready;

endmodule
